// ----- design/ltag_pkg.sv -----
// ----------------------------------------------------------------------------
// ltag_pkg
// Shared widths, latencies and transaction types of the lifted triangle area
// and gradient pipeline.
// ----------------------------------------------------------------------------
package ltag_pkg;

  localparam int COORD_W = 24;
  localparam int REST_W = 48;
  localparam int OUT_W = 48;
  localparam int EDGE_W = COORD_W + 1;
  localparam int EMAG_W = EDGE_W;
  localparam int SQ_W = 2 * COORD_W + 1;
  localparam int D_W = 50;
  localparam int G_W = D_W + 2;
  localparam int GMAG_W = G_W - 1;
  localparam int RAD_W = 2 * D_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int AREA_W = ROOT_W - 2;
  localparam int AREA_DIVISOR = 8;
  localparam int DIV_SHIFT = $clog2(AREA_DIVISOR);
  localparam int DIV_W = AREA_W + DIV_SHIFT;
  localparam int TERM_W = GMAG_W + EMAG_W;
  localparam int MAG_W = TERM_W + 1;
  localparam int FRAC_SHIFT = 16;
  localparam int NUM_W = MAG_W + FRAC_SHIFT;
  localparam int QUOT_W = OUT_W;
  localparam int WORK_W = DIV_W + QUOT_W;

  localparam logic [OUT_W-1:0] GRAD_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] GRAD_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] AREA_MAX = {OUT_W{1'b1}};

  localparam int FRONT_LAT = 5;
  localparam int MUL_LAT = 3;
  localparam int SQRT_LAT = ROOT_W;
  localparam int NUMER_LAT = MUL_LAT + 3;
  localparam int DIV_LAT = QUOT_W + 2;
  localparam int AREA_READY = FRONT_LAT + MUL_LAT + 1 + SQRT_LAT + 1;
  localparam int NUM_DELAY = AREA_READY - FRONT_LAT - NUMER_LAT;
  localparam int TOTAL_LAT = AREA_READY + DIV_LAT + 1;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic [COORD_W-1:0] third_x;
    logic [COORD_W-1:0] third_y;
    logic [REST_W-1:0]  rest_a;
    logic [REST_W-1:0]  rest_b;
    logic [REST_W-1:0]  rest_c;
  } operand_t;

  typedef struct packed {
    logic [OUT_W-1:0] lifted_area;
    logic [OUT_W-1:0] grad_first_x;
    logic [OUT_W-1:0] grad_first_y;
    logic [OUT_W-1:0] grad_second_x;
    logic [OUT_W-1:0] grad_second_y;
    logic [OUT_W-1:0] grad_third_x;
    logic [OUT_W-1:0] grad_third_y;
    logic             degenerate;
  } result_t;

  typedef struct packed {
    logic [D_W-1:0]                  d_first;
    logic [D_W-1:0]                  d_second;
    logic [2:0][GMAG_W-1:0]          g_mag;
    logic [2:0]                      g_neg;
    logic [2:0][1:0][EMAG_W-1:0]     e_mag;
    logic [2:0][1:0]                 e_neg;
  } front_t;

  typedef struct packed {
    logic [GMAG_W-1:0] g_mag;
    logic              g_neg;
    logic [EMAG_W-1:0] e_mag;
    logic              e_neg;
  } term_t;

  typedef struct packed {
    logic [NUM_W-1:0] mag;
    logic             neg;
  } numer_t;

endpackage

// ----- design/ltag_delay.sv -----
// ----------------------------------------------------------------------------
// ltag_delay
// Fixed-length register line that aligns side data with a pipeline.
// ----------------------------------------------------------------------------
module ltag_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int k = 1; k < DEPTH; k++) begin
      line[k] <= line[k-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

// ----- design/ltag_umul.sv -----
// ----------------------------------------------------------------------------
// ltag_umul
// Three-stage unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module ltag_umul #(
  parameter int AW = ltag_pkg::GMAG_W,
  parameter int BW = ltag_pkg::GMAG_W
) (
  input  logic              clk,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic [AW+BW-1:0]  p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] p00;
  logic [AL+BH-1:0] p01;
  logic [AH+BL-1:0] p10;
  logic [AH+BH-1:0] p11;
  logic [PW-1:0]    cat;
  logic [PW-1:0]    mid;

  always_ff @(posedge clk) begin
    p00 <= a[AL-1:0] * b[BL-1:0];
    p01 <= a[AL-1:0] * b[BW-1:BL];
    p10 <= a[AW-1:AL] * b[BL-1:0];
    p11 <= a[AW-1:AL] * b[BW-1:BL];
    cat <= {p11, p00};
    mid <= (PW'(p01) << BL) + (PW'(p10) << AL);
    p   <= cat + mid;
  end

endmodule

// ----- design/ltag_front.sv -----
// ----------------------------------------------------------------------------
// ltag_front
// Edge vectors, lifted squared lengths and their Heron combinations.
// ----------------------------------------------------------------------------
module ltag_front (
  input  logic               clk,
  input  ltag_pkg::operand_t operand,
  output ltag_pkg::front_t   front
);

  logic [2:0][1:0][ltag_pkg::EDGE_W-1:0] edge_s1;
  logic [2:0][ltag_pkg::REST_W-1:0]      rest_s1;
  logic [2:0][1:0][ltag_pkg::SQ_W-1:0]   sq_s2;
  logic [2:0][ltag_pkg::REST_W-1:0]      rest_s2;
  logic [2:0][1:0][ltag_pkg::EMAG_W-1:0] emag_s2;
  logic [2:0][1:0]                       eneg_s2;
  logic [2:0][ltag_pkg::D_W-1:0]         d_s3;
  logic [2:0][1:0][ltag_pkg::EMAG_W-1:0] emag_s3;
  logic [2:0][1:0]                       eneg_s3;
  logic [2:0][ltag_pkg::G_W-1:0]         g_s4;
  logic [1:0][ltag_pkg::D_W-1:0]         d_s4;
  logic [2:0][1:0][ltag_pkg::EMAG_W-1:0] emag_s4;
  logic [2:0][1:0]                       eneg_s4;
  logic [2:0][ltag_pkg::GMAG_W-1:0]      gmag_s5;
  logic [2:0]                            gneg_s5;
  logic [1:0][ltag_pkg::D_W-1:0]         d_s5;
  logic [2:0][1:0][ltag_pkg::EMAG_W-1:0] emag_s5;
  logic [2:0][1:0]                       eneg_s5;

  logic signed [2*ltag_pkg::EDGE_W-1:0]  sq_full [3][2];
  logic [ltag_pkg::G_W-1:0]              dz [3];
  logic [2:0][ltag_pkg::G_W-1:0]         g_next;
  logic [2:0][ltag_pkg::G_W-1:0]         gabs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 2; a++) begin
        sq_full[i][a] = $signed(edge_s1[i][a]) * $signed(edge_s1[i][a]);
      end
      dz[i] = ltag_pkg::G_W'(d_s3[i]);
      gabs[i] = g_s4[i][ltag_pkg::G_W-1] ? -g_s4[i] : g_s4[i];
    end
    g_next[0] = dz[1] + dz[2] - dz[0];
    g_next[1] = dz[2] + dz[0] - dz[1];
    g_next[2] = dz[0] + dz[1] - dz[2];
  end

  always_ff @(posedge clk) begin
    edge_s1[0][0] <= {operand.second_x[ltag_pkg::COORD_W-1], operand.second_x}
                   - {operand.third_x[ltag_pkg::COORD_W-1], operand.third_x};
    edge_s1[0][1] <= {operand.second_y[ltag_pkg::COORD_W-1], operand.second_y}
                   - {operand.third_y[ltag_pkg::COORD_W-1], operand.third_y};
    edge_s1[1][0] <= {operand.third_x[ltag_pkg::COORD_W-1], operand.third_x}
                   - {operand.first_x[ltag_pkg::COORD_W-1], operand.first_x};
    edge_s1[1][1] <= {operand.third_y[ltag_pkg::COORD_W-1], operand.third_y}
                   - {operand.first_y[ltag_pkg::COORD_W-1], operand.first_y};
    edge_s1[2][0] <= {operand.first_x[ltag_pkg::COORD_W-1], operand.first_x}
                   - {operand.second_x[ltag_pkg::COORD_W-1], operand.second_x};
    edge_s1[2][1] <= {operand.first_y[ltag_pkg::COORD_W-1], operand.first_y}
                   - {operand.second_y[ltag_pkg::COORD_W-1], operand.second_y};
    rest_s1[0] <= operand.rest_a;
    rest_s1[1] <= operand.rest_b;
    rest_s1[2] <= operand.rest_c;

    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 2; a++) begin
        sq_s2[i][a]   <= sq_full[i][a][ltag_pkg::SQ_W-1:0];
        eneg_s2[i][a] <= edge_s1[i][a][ltag_pkg::EDGE_W-1];
        emag_s2[i][a] <= edge_s1[i][a][ltag_pkg::EDGE_W-1] ? -edge_s1[i][a]
                                                           : edge_s1[i][a];
      end
      rest_s2[i] <= rest_s1[i];
      d_s3[i] <= ltag_pkg::D_W'(sq_s2[i][0]) + ltag_pkg::D_W'(sq_s2[i][1])
               + ltag_pkg::D_W'(rest_s2[i]);
      g_s4[i] <= g_next[i];
      gmag_s5[i] <= gabs[i][ltag_pkg::GMAG_W-1:0];
      gneg_s5[i] <= g_s4[i][ltag_pkg::G_W-1];
    end
    emag_s3 <= emag_s2;
    eneg_s3 <= eneg_s2;
    emag_s4 <= emag_s3;
    eneg_s4 <= eneg_s3;
    emag_s5 <= emag_s4;
    eneg_s5 <= eneg_s4;
    d_s4[0] <= d_s3[0];
    d_s4[1] <= d_s3[1];
    d_s5    <= d_s4;
  end

  always_comb begin
    front.d_first  = d_s5[0];
    front.d_second = d_s5[1];
    front.g_mag    = gmag_s5;
    front.g_neg    = gneg_s5;
    front.e_mag    = emag_s5;
    front.e_neg    = eneg_s5;
  end

endmodule

// ----- design/ltag_sqrt.sv -----
// ----------------------------------------------------------------------------
// ltag_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ltag_sqrt (
  input  logic                        clk,
  input  logic [ltag_pkg::RAD_W-1:0]  rad,
  output logic [ltag_pkg::ROOT_W-1:0] root
);

  localparam int RW = ltag_pkg::RAD_W;
  localparam int QW = ltag_pkg::ROOT_W;

  logic [RW-1:0] rem  [QW+1];
  logic [QW-1:0] part [QW+1];

  assign rem[0]  = rad;
  assign part[0] = '0;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [RW-1:0] trial;
    logic [RW:0]   diff;

    assign trial = (RW'(part[s]) << (B + 1)) | (RW'(1) << (2 * B));
    assign diff  = {1'b0, rem[s]} - {1'b0, trial};

    always_ff @(posedge clk) begin
      if (!diff[RW]) begin
        rem[s+1]  <= diff[RW-1:0];
        part[s+1] <= part[s] | (QW'(1) << B);
      end else begin
        rem[s+1]  <= rem[s];
        part[s+1] <= part[s];
      end
    end
  end

  assign root = part[QW];

endmodule

// ----- design/ltag_numer.sv -----
// ----------------------------------------------------------------------------
// ltag_numer
// Signed gradient numerator ga*ea - gb*eb, returned as scaled magnitude and sign.
// ----------------------------------------------------------------------------
module ltag_numer (
  input  logic             clk,
  input  ltag_pkg::term_t  term_a,
  input  ltag_pkg::term_t  term_b,
  output ltag_pkg::numer_t numer
);

  localparam int TW = ltag_pkg::TERM_W;

  logic [TW-1:0]  prod_a;
  logic [TW-1:0]  prod_b;
  logic [1:0]     sign_d;
  logic [TW:0]    term_sa;
  logic [TW:0]    term_sb;
  logic [TW+1:0]  diff;
  logic [TW+1:0]  diff_abs;

  ltag_umul #(.AW(ltag_pkg::GMAG_W), .BW(ltag_pkg::EMAG_W)) u_mul_a (
    .clk (clk),
    .a   (term_a.g_mag),
    .b   (term_a.e_mag),
    .p   (prod_a)
  );

  ltag_umul #(.AW(ltag_pkg::GMAG_W), .BW(ltag_pkg::EMAG_W)) u_mul_b (
    .clk (clk),
    .a   (term_b.g_mag),
    .b   (term_b.e_mag),
    .p   (prod_b)
  );

  ltag_delay #(.WIDTH(2), .DEPTH(ltag_pkg::MUL_LAT)) u_sign (
    .clk  (clk),
    .din  ({term_a.g_neg ^ term_a.e_neg, term_b.g_neg ^ term_b.e_neg}),
    .dout (sign_d)
  );

  assign diff_abs = diff[TW+1] ? -diff : diff;

  always_ff @(posedge clk) begin
    term_sa <= sign_d[1] ? (TW+1)'(0) - {1'b0, prod_a} : {1'b0, prod_a};
    term_sb <= sign_d[0] ? (TW+1)'(0) - {1'b0, prod_b} : {1'b0, prod_b};
    diff    <= {term_sa[TW], term_sa} - {term_sb[TW], term_sb};
    numer.neg <= diff[TW+1];
    numer.mag <= {diff_abs[TW:0], {ltag_pkg::FRAC_SHIFT{1'b0}}};
  end

endmodule

// ----- design/ltag_div.sv -----
// ----------------------------------------------------------------------------
// ltag_div
// Pipelined restoring divider with signed saturation of the quotient.
// ----------------------------------------------------------------------------
module ltag_div (
  input  logic                       clk,
  input  ltag_pkg::numer_t           numer,
  input  logic [ltag_pkg::DIV_W-1:0] divisor,
  output logic [ltag_pkg::OUT_W-1:0] quot
);

  localparam int WW = ltag_pkg::WORK_W;
  localparam int QW = ltag_pkg::QUOT_W;
  localparam int DW = ltag_pkg::DIV_W;

  logic [WW-1:0] rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic          neg [QW+1];
  logic          ovf [QW+1];
  logic [QW-1:0] qf;

  always_ff @(posedge clk) begin
    rem[0] <= WW'(numer.mag);
    dv[0]  <= divisor;
    q[0]   <= '0;
    neg[0] <= numer.neg;
    ovf[0] <= WW'(numer.mag) >= (WW'(divisor) << QW);
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int I = QW - 1 - k;
    logic [WW-1:0] shifted;
    logic [WW:0]   diff;

    assign shifted = WW'(dv[k]) << I;
    assign diff    = {1'b0, rem[k]} - {1'b0, shifted};

    always_ff @(posedge clk) begin
      dv[k+1]  <= dv[k];
      neg[k+1] <= neg[k];
      ovf[k+1] <= ovf[k];
      if (!diff[WW]) begin
        rem[k+1] <= diff[WW-1:0];
        q[k+1]   <= q[k] | (QW'(1) << I);
      end else begin
        rem[k+1] <= rem[k];
        q[k+1]   <= q[k];
      end
    end
  end

  assign qf = q[QW];

  always_ff @(posedge clk) begin
    if (neg[QW]) begin
      if (ovf[QW] || (qf[QW-1] && (|qf[QW-2:0]))) begin
        quot <= ltag_pkg::GRAD_MIN;
      end else begin
        quot <= -qf;
      end
    end else begin
      if (ovf[QW] || qf[QW-1]) begin
        quot <= ltag_pkg::GRAD_MAX;
      end else begin
        quot <= qf;
      end
    end
  end

endmodule

// ----- design/lifted_triangle_area_gradient.sv -----
// ----------------------------------------------------------------------------
// lifted_triangle_area_gradient
// Heron area of lifted squared edge lengths and its vertex gradient.
// ----------------------------------------------------------------------------
// Usage: raise start with a triangle on operand; the transaction is taken at
// a rising edge where start is high and busy is low. busy is high only while
// rst is applied and for the cycle after, so a new triangle may enter on
// every clock cycle.
// Each transaction gives one result: done is high for exactly one cycle with
// result valid, in input order.
// Throughput: one triangle per cycle. Latency is set by the square root
// (one root bit per stage, 51 stages) followed by the gradient dividers (one
// quotient bit per stage, 48 stages plus entry and saturation), with the
// edge front end, the split multipliers and the output register around them.
// Reset clears the in-flight valid bits; triangles still in the pipeline are
// dropped. The receiver cannot hold results off, and the pipeline never
// stalls.
// ----------------------------------------------------------------------------
module lifted_triangle_area_gradient (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ltag_pkg::operand_t operand,
  output logic               done,
  output ltag_pkg::result_t  result
);

  localparam int TL = ltag_pkg::TOTAL_LAT;

  logic [TL-1:0]                         vld;
  ltag_pkg::front_t                      front;
  logic [2*ltag_pkg::D_W-1:0]            prod_dd;
  logic [2*ltag_pkg::GMAG_W-1:0]         prod_gg;
  logic [ltag_pkg::RAD_W-1:0]            four;
  logic [ltag_pkg::RAD_W:0]              rad_diff;
  logic [ltag_pkg::RAD_W-1:0]            rad;
  logic [ltag_pkg::ROOT_W-1:0]           root;
  logic [ltag_pkg::AREA_W-1:0]           area;
  logic [ltag_pkg::DIV_W-1:0]            divisor;
  logic                                  degenerate;
  logic [ltag_pkg::OUT_W-1:0]            lifted;
  logic [ltag_pkg::OUT_W:0]              area_info;
  logic [2:0][1:0][ltag_pkg::OUT_W-1:0]  quot;
  ltag_pkg::result_t                     result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[TL-2:0], start & ~busy};
    end
  end

  assign done = vld[TL-1];

  ltag_front u_front (
    .clk     (clk),
    .operand (operand),
    .front   (front)
  );

  ltag_umul #(.AW(ltag_pkg::D_W), .BW(ltag_pkg::D_W)) u_mul_dd (
    .clk (clk),
    .a   (front.d_first),
    .b   (front.d_second),
    .p   (prod_dd)
  );

  ltag_umul #(.AW(ltag_pkg::GMAG_W), .BW(ltag_pkg::GMAG_W)) u_mul_gg (
    .clk (clk),
    .a   (front.g_mag[2]),
    .b   (front.g_mag[2]),
    .p   (prod_gg)
  );

  assign four     = {prod_dd, 2'b00};
  assign rad_diff = {1'b0, four} - {1'b0, ltag_pkg::RAD_W'(prod_gg)};
  assign area     = root[ltag_pkg::ROOT_W-1:2];

  always_ff @(posedge clk) begin
    rad        <= rad_diff[ltag_pkg::RAD_W] ? '0 : rad_diff[ltag_pkg::RAD_W-1:0];
    divisor    <= {area, {ltag_pkg::DIV_SHIFT{1'b0}}};
    degenerate <= (area == '0);
    lifted     <= (|area[ltag_pkg::AREA_W-1:ltag_pkg::OUT_W]) ? ltag_pkg::AREA_MAX
                                                             : area[ltag_pkg::OUT_W-1:0];
  end

  ltag_sqrt u_sqrt (
    .clk  (clk),
    .rad  (rad),
    .root (root)
  );

  ltag_delay #(.WIDTH(ltag_pkg::OUT_W + 1), .DEPTH(ltag_pkg::DIV_LAT)) u_area_delay (
    .clk  (clk),
    .din  ({degenerate, lifted}),
    .dout (area_info)
  );

  for (genvar v = 0; v < 3; v++) begin : g_vertex
    localparam int IA = (v + 2) % 3;
    localparam int IB = (v + 1) % 3;
    for (genvar a = 0; a < 2; a++) begin : g_axis
      ltag_pkg::term_t  term_a;
      ltag_pkg::term_t  term_b;
      ltag_pkg::numer_t numer;
      ltag_pkg::numer_t numer_d;

      always_comb begin
        term_a.g_mag = front.g_mag[IA];
        term_a.g_neg = front.g_neg[IA];
        term_a.e_mag = front.e_mag[IA][a];
        term_a.e_neg = front.e_neg[IA][a];
        term_b.g_mag = front.g_mag[IB];
        term_b.g_neg = front.g_neg[IB];
        term_b.e_mag = front.e_mag[IB][a];
        term_b.e_neg = front.e_neg[IB][a];
      end

      ltag_numer u_numer (
        .clk    (clk),
        .term_a (term_a),
        .term_b (term_b),
        .numer  (numer)
      );

      ltag_delay #(.WIDTH($bits(ltag_pkg::numer_t)), .DEPTH(ltag_pkg::NUM_DELAY)) u_align (
        .clk  (clk),
        .din  (numer),
        .dout (numer_d)
      );

      ltag_div u_div (
        .clk     (clk),
        .numer   (numer_d),
        .divisor (divisor),
        .quot    (quot[v][a])
      );
    end
  end

  always_comb begin
    result_next.lifted_area   = area_info[ltag_pkg::OUT_W-1:0];
    result_next.degenerate    = area_info[ltag_pkg::OUT_W];
    result_next.grad_first_x  = area_info[ltag_pkg::OUT_W] ? '0 : quot[0][0];
    result_next.grad_first_y  = area_info[ltag_pkg::OUT_W] ? '0 : quot[0][1];
    result_next.grad_second_x = area_info[ltag_pkg::OUT_W] ? '0 : quot[1][0];
    result_next.grad_second_y = area_info[ltag_pkg::OUT_W] ? '0 : quot[1][1];
    result_next.grad_third_x  = area_info[ltag_pkg::OUT_W] ? '0 : quot[2][0];
    result_next.grad_third_y  = area_info[ltag_pkg::OUT_W] ? '0 : quot[2][1];
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
